[sv/row_mean_sd_contrast_normalizer_top_assert.svh]
`ifndef ROW_MEAN_SD_CONTRAST_NORMALIZER_TOP_ASSERT_SVH
`define ROW_MEAN_SD_CONTRAST_NORMALIZER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define RMSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmsd: assertion failed");

// Property that must hold in the cycle after a trigger.
`define RMSD_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("rmsd: assertion failed");

`endif

[sv/rmsd_pkg.sv]
package rmsd_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 512;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;

  // configuration register
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;
  localparam logic [APB_AW-3:0] REG_SAMPLE_COUNT = '0;

  // fixed point
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned PIX_W     = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

endpackage

[sv/rmsd_if.sv]
interface rmsd_in_if #(
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

interface rmsd_out_if;
  logic                            valid;
  logic                            ready;
  logic [rmsd_pkg::PIX_W-1:0]      pixel;
  logic                            row_end;

  modport source (output valid, output pixel, output row_end, input ready);
  modport sink   (input valid, input pixel, input row_end, output ready);
endinterface

[sv/row_mean_sd_contrast_normalizer_top.sv]
// Channel   Role    Handshake      Payload
// in_i      sink    valid/ready    action, sample
// out_o     source  valid/ready    pixel, row_end
// APB       slave   psel/penable   sample_count at byte address 0
//
// A load steps through S_IDLE and S_ACC in the back end, an emit through S_IDLE,
// S_PIX and S_PUT, with S_PDIV added when the eight-step pixel divide runs.
// Completing a row adds the bit-serial mean and mean-square divides, S_MSQ,
// S_VAR and the two-bit-per-step square root.
// A 4-beat queue lets the input side keep accepting while the back end is busy
// or the output register holds an untaken beat. Reset clears all control state
// at once; the sample store needs no clearing pass.
module row_mean_sd_contrast_normalizer_top #(
  parameter int unsigned MAX_SAMPLES = rmsd_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rmsd_in_if.sink                     in_i,
  rmsd_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmsd_pkg::APB_AW-1:0] paddr,
  input  logic [rmsd_pkg::APB_DW-1:0] pwdata,
  output logic [rmsd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import rmsd_pkg::*;

  logic [CFG_W-1:0]     sample_count_q;
  logic                 reg_hit;
  logic                 full, push, q_valid, q_pop;
  logic [SAMPLE_BITS:0] push_data, q_data;

  assign reg_hit = (paddr[APB_AW-1:2] == REG_SAMPLE_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(sample_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CFG_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      sample_count_q <= pwdata[CFG_W-1:0];
    end
  end

  rmsd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .data_o(push_data)
  );

  rmsd_fifo #(
    .WIDTH(SAMPLE_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  rmsd_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .sample_count_i(sample_count_q),
    .out_o         (out_o)
  );

endmodule

[sv/rmsd_fifo.sv]
module rmsd_fifo #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = rmsd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

`include "row_mean_sd_contrast_normalizer_top_assert.svh"
  `RMSD_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `RMSD_ASSERT(a_no_pop_empty, pop_i |-> (count_q != '0))
  `RMSD_ASSERT_NEXT(a_push_grows, push_i && !pop_i, count_q == $past(count_q) + CW'(1))

endmodule

[sv/rmsd_front.sv]
module rmsd_front #(
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF
) (
  rmsd_in_if.sink              in_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [SAMPLE_BITS:0] data_o
);
  import rmsd_pkg::*;

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  op_e                    op;

  // the most negative sample folds to its own bit pattern, read unsigned
  assign raw    = in_i.sample;
  assign mag    = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  assign op     = in_i.action ? OP_EMIT : OP_LOAD;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign data_o     = {op, mag};

endmodule

[sv/rmsd_back.sv]
module rmsd_back #(
  parameter int unsigned MAX_SAMPLES = rmsd_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  logic [SAMPLE_BITS:0]       q_data_i,
  output logic                       q_pop_o,
  input  logic [rmsd_pkg::CFG_W-1:0] sample_count_i,
  rmsd_out_if.source                 out_o
);
  import rmsd_pkg::*;

  localparam int unsigned MAG_W    = SAMPLE_BITS;
  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned MEM_AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned SUM_W    = MAG_W + CNT_W;
  localparam int unsigned SQ_W     = 2 * MAG_W + CNT_W;
  localparam int unsigned MEAN_W   = MAG_W + FRAC_BITS;
  localparam int unsigned AVG_W    = 2 * MEAN_W;
  localparam int unsigned SD_W     = MEAN_W;
  localparam int unsigned SPREAD_W = SD_W + 2;
  localparam int unsigned REM_W    = SPREAD_W + 1;
  localparam int unsigned SQR_W    = SD_W + 3;
  localparam int unsigned NUM_W    = SQ_W + 2 * FRAC_BITS;
  localparam int unsigned ITER_W   = $clog2(NUM_W + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_ACC   = 10'b00_0000_0010,
    S_DMEAN = 10'b00_0000_0100,
    S_DAVG  = 10'b00_0000_1000,
    S_MSQ   = 10'b00_0001_0000,
    S_VAR   = 10'b00_0010_0000,
    S_SQRT  = 10'b00_0100_0000,
    S_PIX   = 10'b00_1000_0000,
    S_PDIV  = 10'b01_0000_0000,
    S_PUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // row state
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SQ_W-1:0]     sqs_q, sqs_d;
  logic [CNT_W-1:0]    loaded_q, loaded_d, emitted_q, emitted_d;
  logic [MEAN_W-1:0]   mean_q, mean_d;
  logic [SPREAD_W-1:0] spread_q, spread_d;
  logic                stats_q, stats_d;
  logic                out_valid_q, out_valid_d;

  // datapath
  logic [2*MAG_W-1:0]  sqp_q, sqp_d;
  logic [NUM_W-1:0]    num_q, num_d, quo_q, quo_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [SPREAD_W-1:0] den_q, den_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic [AVG_W-1:0]    var_q, var_d, msq_q, msq_d;
  logic [SQR_W-1:0]    srem_q, srem_d;
  logic [SD_W-1:0]     root_q, root_d;
  logic [PIX_W-1:0]    c_q, c_d, pix_q, pix_d;
  logic                row_end_q, row_end_d;
  logic [MAG_W-1:0]    rd_q;
  logic [MAG_W-1:0]    mem_q [MAX_SAMPLES];

  logic                mem_we, mem_re;
  logic [MAG_W-1:0]    q_mag;
  op_e                 q_op;
  logic [CNT_W-1:0]    limit;
  logic                last;

  // shared divider step
  logic [REM_W-1:0]    rem_sh, rem_nx;
  logic                div_ge;
  logic [NUM_W-1:0]    quo_nx;
  // square root step
  logic [SQR_W-1:0]    sq_sh, trial, srem_nx;
  logic                sq_ge;
  logic [SD_W-1:0]     root_nx;
  // pixel
  logic [MEAN_W-1:0]   mbig, diff;

  assign q_op  = op_e'(q_data_i[SAMPLE_BITS]);
  assign q_mag = q_data_i[SAMPLE_BITS-1:0];

  always_comb begin
    if (sample_count_i == '0) begin
      limit = CNT_W'(1);
    end else if (32'(sample_count_i) > MAX_SAMPLES) begin
      limit = CNT_W'(MAX_SAMPLES);
    end else begin
      limit = CNT_W'(sample_count_i);
    end
  end

  assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign div_ge = (rem_sh >= {1'b0, den_q});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_nx = {quo_q[NUM_W-2:0], div_ge};

  assign sq_sh   = {srem_q[SQR_W-3:0], var_q[AVG_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign sq_ge   = (sq_sh >= trial);
  assign srem_nx = sq_ge ? (sq_sh - trial) : sq_sh;
  assign root_nx = {root_q[SD_W-2:0], sq_ge};

  assign mbig = {rd_q, FRAC_BITS'(0)};
  assign diff = mbig - mean_q;
  assign last = (emitted_q + CNT_W'(1)) >= loaded_q;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    sqs_d       = sqs_q;
    loaded_d    = loaded_q;
    emitted_d   = emitted_q;
    mean_d      = mean_q;
    spread_d    = spread_q;
    stats_d     = stats_q;
    out_valid_d = out_valid_q && !out_o.ready;
    sqp_d       = sqp_q;
    num_d       = num_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    iter_d      = iter_q;
    var_d       = var_q;
    msq_d       = msq_q;
    srem_d      = srem_q;
    root_d      = root_q;
    c_d         = c_q;
    pix_d       = pix_q;
    row_end_d   = row_end_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_op == OP_LOAD) begin
            // drop loads once the row is complete
            if (!stats_q && (32'(loaded_q) < MAX_SAMPLES)) begin
              mem_we   = 1'b1;
              sum_d    = sum_q + SUM_W'(q_mag);
              sqp_d    = q_mag * q_mag;
              loaded_d = loaded_q + CNT_W'(1);
              state_d  = S_ACC;
            end
          end else if (stats_q) begin
            mem_re  = 1'b1;
            state_d = S_PIX;
          end
        end
      end
      S_ACC: begin
        sqs_d = sqs_q + SQ_W'(sqp_q);
        if (loaded_q >= limit) begin
          rem_d   = '0;
          quo_d   = '0;
          num_d   = NUM_W'({sum_q, FRAC_BITS'(0)}) << (NUM_W - SUM_W - FRAC_BITS);
          den_d   = SPREAD_W'(loaded_q);
          iter_d  = ITER_W'(SUM_W + FRAC_BITS);
          state_d = S_DMEAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DMEAN: begin
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        num_d  = num_q << 1;
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          mean_d  = quo_nx[MEAN_W-1:0];
          rem_d   = '0;
          quo_d   = '0;
          num_d   = {sqs_q, (2 * FRAC_BITS)'(0)};
          iter_d  = ITER_W'(NUM_W);
          state_d = S_DAVG;
        end
      end
      S_DAVG: begin
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        num_d  = num_q << 1;
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          var_d   = quo_nx[AVG_W-1:0];
          state_d = S_MSQ;
        end
      end
      S_MSQ: begin
        msq_d   = mean_q * mean_q;
        state_d = S_VAR;
      end
      S_VAR: begin
        var_d   = (var_q > msq_q) ? (var_q - msq_q) : '0;
        srem_d  = '0;
        root_d  = '0;
        iter_d  = ITER_W'(SD_W);
        state_d = S_SQRT;
      end
      S_SQRT: begin
        srem_d = srem_nx;
        root_d = root_nx;
        var_d  = var_q << 2;
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          spread_d = SPREAD_W'(root_nx) + (SPREAD_W'(root_nx) << 1);
          stats_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_PIX: begin
        if (mbig <= mean_q) begin
          c_d     = '0;
          state_d = S_PUT;
        end else if ((spread_q == '0) || (REM_W'(diff) >= REM_W'(spread_q))) begin
          c_d     = PIX_MAX;
          state_d = S_PUT;
        end else begin
          // quotient stays below 256: eight steps from the remainder diff
          rem_d   = REM_W'(diff);
          quo_d   = '0;
          num_d   = '0;
          den_d   = spread_q;
          iter_d  = ITER_W'(PIX_W);
          state_d = S_PDIV;
        end
      end
      S_PDIV: begin
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        num_d  = num_q << 1;
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          c_d     = quo_nx[PIX_W-1:0];
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          pix_d       = PIX_MAX - c_q;
          row_end_d   = last;
          emitted_d   = emitted_q + CNT_W'(1);
          if (last) begin
            sum_d     = '0;
            sqs_d     = '0;
            loaded_d  = '0;
            emitted_d = '0;
            mean_d    = '0;
            spread_d  = '0;
            stats_d   = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      sqs_q       <= '0;
      loaded_q    <= '0;
      emitted_q   <= '0;
      mean_q      <= '0;
      spread_q    <= '0;
      stats_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sqs_q       <= sqs_d;
      loaded_q    <= loaded_d;
      emitted_q   <= emitted_d;
      mean_q      <= mean_d;
      spread_q    <= spread_d;
      stats_q     <= stats_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqp_q     <= sqp_d;
    num_q     <= num_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    iter_q    <= iter_d;
    var_q     <= var_d;
    msq_q     <= msq_d;
    srem_q    <= srem_d;
    root_q    <= root_d;
    c_q       <= c_d;
    pix_q     <= pix_d;
    row_end_q <= row_end_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[loaded_q[MEM_AW-1:0]] <= q_mag;
    end
    if (mem_re) begin
      rd_q <= mem_q[emitted_q[MEM_AW-1:0]];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pixel   = pix_q;
  assign out_o.row_end = row_end_q;

`include "row_mean_sd_contrast_normalizer_top_assert.svh"
  `RMSD_ASSERT(a_emit_within_row, emitted_q <= loaded_q)
  `RMSD_ASSERT(a_stats_need_samples, stats_q |-> (loaded_q != '0))
  `RMSD_ASSERT(a_beat_from_put, $rose(out_valid_q) |-> $past(state_q == S_PUT))

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmsd_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } pixel_beat_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_REG_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    op_e               op;
    logic signed [15:0] smp;
    int unsigned       reg_val;
    bit                typed;
    logic [7:0]        pix;
    logic              last;
  } script_row_t;

  localparam int unsigned ROW_MAX = MAX_SAMPLES_DEF;
  localparam int unsigned SETTLE  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  rmsd_in_if  in_if ();
  rmsd_out_if out_if ();

  row_mean_sd_contrast_normalizer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the row statistics
  logic [15:0]       mags [ROW_MAX];
  longint unsigned   mag_total, sq_total, mean_q8, spread3;
  int unsigned       n_loaded, n_emitted, row_len_reg;
  bit                stats_done;
  pixel_beat_t       pending_pixels [$];
  pixel_beat_t       got, want;
  int unsigned       src_idle, snk_idle, errs;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_row();
    mag_total = 0; sq_total = 0; n_loaded = 0; n_emitted = 0;
    mean_q8 = 0; spread3 = 0; stats_done = 0;
  endfunction

  function automatic int unsigned row_limit();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > ROW_MAX) return ROW_MAX;
    return row_len_reg;
  endfunction

  // advance the shadow by one accepted beat; return 1 if a pixel is due
  function automatic bit normalise_beat(op_e op, logic signed [15:0] s);
    longint unsigned m, c, avg2, msq, vr, d;
    pixel_beat_t pb;
    if (op == OP_LOAD) begin
      if (stats_done || n_loaded >= ROW_MAX) return 0;
      m = (s < 0) ? longint'(-int'(s)) : longint'(s);
      mags[n_loaded] = m[15:0];
      mag_total += m;
      sq_total += m * m;
      n_loaded++;
      if (n_loaded >= row_limit()) begin
        mean_q8 = (mag_total << 8) / n_loaded;
        avg2 = (sq_total << 16) / n_loaded;
        msq = mean_q8 * mean_q8;
        vr = (avg2 > msq) ? avg2 - msq : 0;
        spread3 = 3 * int_sqrt(vr);
        stats_done = 1;
      end
      return 0;
    end
    if (!stats_done || n_emitted >= ROW_MAX) return 0;
    m = longint'(mags[n_emitted]) << 8;
    if (m <= mean_q8) c = 0;
    else if (spread3 == 0) c = 255;
    else begin
      d = ((m - mean_q8) << 8) / spread3;
      c = (d > 255) ? 255 : d;
    end
    n_emitted++;
    pb.pix = PIX_MAX - c[7:0];
    pb.last = (n_emitted >= n_loaded);
    pending_pixels.push_back(pb);
    if (pb.last) clear_row();
    return 1;
  endfunction

  task automatic send_beat(op_e op, logic signed [15:0] s, output bit made);
    if ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= op;
    in_if.sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    made = normalise_beat(op, s);
  endtask

  // hold until the back end is quiet, then write the row length
  task automatic write_row_len(int unsigned v);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= APB_AW'(REG_SAMPLE_COUNT) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    row_len_reg = v & 32'h3FF;
  endtask

  function automatic logic signed [15:0] pick_sample(logic signed [15:0] flat);
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(16)) - 8);
      4, 5: return flat;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle);
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.pix = out_if.pixel;
      got.last = out_if.row_end;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, actual %h/%b", $realtime, got.pix, got.last);
        errs++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.pix !== want.pix) begin
          $display("%0t: pixel expected %h actual %h", $realtime, want.pix, got.pix);
          errs++;
        end
        if (got.last !== want.last) begin
          $display("%0t: row_end expected %b actual %b", $realtime, want.last, got.last);
          errs++;
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    script_row_t script [$];
    script_row_t r;
    bit made;
    int unsigned n, reg_v, phase_items, big_rows, eff;
    logic signed [15:0] flat;

    in_if.valid = 1'b0; in_if.action = OP_LOAD; in_if.sample = '0;
    out_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errs = 0; big_rows = 0;
    src_idle = 6; snk_idle = 81;
    row_len_reg = CFG_RESET;
    clear_row();

    // emit straight after reset, single-sample row, emit with no row
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 0, 0, 0});
    script.push_back('{ROW_REG_WRITE, OP_LOAD, 0, 1, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 100, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 1, 8'd255, 1'b1});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 0, 0, 0});
    // field extremes
    script.push_back('{ROW_REG_WRITE, OP_LOAD, 0, 2, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 16'sh8000, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 16'sh7FFF, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 1, 8'd255, 1'b1});
    // zero spread, plus a load on a complete row
    script.push_back('{ROW_BEAT, OP_LOAD, 0, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 0, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 5, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 1, 8'd255, 1'b0});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 1, 8'd255, 1'b1});
    // row length lowered in mid-row
    script.push_back('{ROW_REG_WRITE, OP_LOAD, 0, 512, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 1000, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, -1, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 20000, 0, 0, 0, 0});
    script.push_back('{ROW_REG_WRITE, OP_LOAD, 0, 2, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, -7, 0, 0, 0, 0});
    repeat (4) script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 0, 0, 0});
    // zero length acts as one
    script.push_back('{ROW_REG_WRITE, OP_LOAD, 0, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_LOAD, 16'sh7FFF, 0, 0, 0, 0});
    script.push_back('{ROW_BEAT, OP_EMIT, 0, 0, 1, 8'd255, 1'b1});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      r = script[i];
      if (r.kind == ROW_REG_WRITE) begin
        write_row_len(r.reg_val);
      end else begin
        send_beat(r.op, r.smp, made);
        if (r.typed) begin
          if (!made) begin
            $display("%0t: expected pixel %h/%b not predicted", $realtime, r.pix, r.last);
            errs++;
          end else begin
            pending_pixels[$].pix = r.pix;
            pending_pixels[$].last = r.last;
          end
        end
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 6 : (ph == 1) ? 81 : 0;
      snk_idle = (ph == 0) ? 81 : (ph == 1) ? 6 : 0;
      phase_items = 0;
      while (phase_items < 517) begin
        if (big_rows < 2 && $urandom_range(99) < 3) begin
          n = ROW_MAX;
          big_rows++;
        end else if ($urandom_range(99) < 85) begin
          n = $urandom_range(24, 1);
        end else begin
          n = $urandom_range(100, 25);
        end
        if (n == ROW_MAX) reg_v = $urandom_range(1) ? ROW_MAX : $urandom_range(1023, 513);
        else if (n == 1 && $urandom_range(1)) reg_v = 0;
        else reg_v = n;
        eff = row_limit();
        if (eff != n || $urandom_range(3) == 0) write_row_len(reg_v);
        flat = 16'($urandom);
        for (int k = 0; k < n; k++) begin
          // stray emit on an incomplete row
          if ($urandom_range(99) < 4) send_beat(OP_EMIT, 16'($urandom), made);
          send_beat(OP_LOAD, pick_sample(flat), made);
        end
        if ($urandom_range(99) < 5) send_beat(OP_LOAD, 16'($urandom), made);
        for (int k = 0; k < n; k++) send_beat(OP_EMIT, 16'($urandom), made);
        phase_items += 2 * n;
      end
    end

    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[row_mean_sd_contrast_normalizer_top.f]
+incdir+sv
sv/rmsd_pkg.sv
sv/rmsd_if.sv
sv/rmsd_fifo.sv
sv/rmsd_front.sv
sv/rmsd_back.sv
sv/row_mean_sd_contrast_normalizer_top.sv
tb/sv/testbench.sv
